>>> rtl/bbc_pkg.sv
`default_nettype none
package bbc_pkg;

	localparam int COUNT_BITS = 8;
	localparam int INTEG_BITS = 8;
	localparam int BAR_LEDS   = 5;
	localparam int CFG_BITS   = 8;
	localparam int IDX_BITS   = 8;
	localparam int CMP_BITS   = (INTEG_BITS > CFG_BITS ? INTEG_BITS : CFG_BITS) + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [INTEG_BITS-1:0] INTEG_MAX = {INTEG_BITS{1'b1}};

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(4);
	localparam logic [CFG_BITS-1:0] ALARM_RESET    = CFG_BITS'(4);

	typedef enum logic [IDX_BITS-1:0] {
		REG_DEBOUNCE_LIMIT = IDX_BITS'(0),
		REG_ALARM_ABOVE    = IDX_BITS'(1)
	} reg_idx_t;

	typedef enum logic [1:0] {
		ZONE_NONE = 2'd0,
		ZONE_A    = 2'd1,
		ZONE_BOTH = 2'd2,
		ZONE_B    = 2'd3
	} zone_t;

	typedef struct packed {
		logic [INTEG_BITS-1:0] integ;
		logic                  level;
	} beam_state_t;

	typedef struct packed {
		logic beam_a_hit;
		logic beam_b_hit;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] occupancy;
		logic                  entry_seen;
		logic                  exit_seen;
		logic                  pass_error;
		logic                  capacity_alarm;
		logic [BAR_LEDS-1:0]   level_bar;
		logic [1:0]            zone_code;
		logic                  clean_a;
		logic                  clean_b;
	} out_item_t;

endpackage
`default_nettype wire

>>> rtl/bbc_debounce.sv
`default_nettype none
module bbc_debounce (
	input  wire logic                         hit,
	input  wire logic [bbc_pkg::CFG_BITS-1:0] limit,
	input  wire bbc_pkg::beam_state_t         cur,
	output bbc_pkg::beam_state_t              nxt
);
	import bbc_pkg::*;

	logic [INTEG_BITS-1:0] v;
	logic [CMP_BITS-1:0]   v_ext;
	logic [CMP_BITS-1:0]   lim_ext;
	logic [CMP_BITS-1:0]   cur_ext;

	always_comb begin
		cur_ext = CMP_BITS'(cur.integ);
		lim_ext = CMP_BITS'(limit);
		v = cur.integ;
		if (!hit) begin
			if (cur.integ != '0)
				v = cur.integ - INTEG_BITS'(1);
		end else if ((cur_ext < lim_ext) && (cur.integ != INTEG_MAX)) begin
			v = cur.integ + INTEG_BITS'(1);
		end
		v_ext = CMP_BITS'(v);
		nxt.integ = v;
		nxt.level = cur.level;
		if (v == '0)
			nxt.level = 1'b0;
		else if (v_ext >= lim_ext)
			nxt.level = 1'b1;
	end

endmodule
`default_nettype wire

>>> rtl/bidirectional_beam_counter_unit.sv
// Bidirectional beam people counter.
// The input channel (in_valid, in_stall, in_data) carries one sample tick per
// transaction with the raw levels of the two beams. The output channel
// (out_valid, out_stall, out_data) returns exactly one result per sample: the
// occupancy count, the entry, exit and error events of the pass that just
// ended, the capacity alarm, the thermometer bar, the zone code and both
// debounced levels.
// A sample is processed in the cycle it is accepted; its result is registered
// in the output register, or in the skid register if the output register
// still holds a result. Throughput is one sample per cycle while in_stall is low.
// A two-entry output stage (output register plus a skid register) lets a
// sample be accepted while the previous result waits; in_stall rises only
// when both entries hold results that the receiver has not taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the debounce limit and index 1 the alarm
// threshold. Other indexes are ignored.
// Reset clears the integrators, levels, zone tracking and count, empties the
// output stage, and sets both registers to 4.
`default_nettype none
module bidirectional_beam_counter_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire bbc_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output bbc_pkg::out_item_t                out_data,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [bbc_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [bbc_pkg::CFG_BITS-1:0] cfg_data
);
	import bbc_pkg::*;

	logic [CFG_BITS-1:0]   debounce_limit_q;
	logic [CFG_BITS-1:0]   alarm_above_q;
	beam_state_t           beam_a_q;
	beam_state_t           beam_b_q;
	beam_state_t           beam_a_n;
	beam_state_t           beam_b_n;
	zone_t                 zone_now_q;
	zone_t                 zone_first_q;
	zone_t                 zone_next;
	zone_t                 zone_now_n;
	zone_t                 zone_first_n;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_n;
	logic                  entry;
	logic                  leave;
	logic                  err;
	logic                  alarm;
	logic [BAR_LEDS-1:0]   bar;
	out_item_t             result;
	out_item_t             out_q;
	out_item_t             skid_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic                  in_fire;
	logic                  out_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_fire  = out_valid_q && !out_stall;

	bbc_debounce u_deb_a (
		.hit   (in_data.beam_a_hit),
		.limit (debounce_limit_q),
		.cur   (beam_a_q),
		.nxt   (beam_a_n)
	);

	bbc_debounce u_deb_b (
		.hit   (in_data.beam_b_hit),
		.limit (debounce_limit_q),
		.cur   (beam_b_q),
		.nxt   (beam_b_n)
	);

	always_comb begin
		unique case ({beam_a_n.level, beam_b_n.level})
			2'b10:   zone_next = ZONE_A;
			2'b11:   zone_next = ZONE_BOTH;
			2'b01:   zone_next = ZONE_B;
			default: zone_next = ZONE_NONE;
		endcase

		zone_now_n   = zone_now_q;
		zone_first_n = zone_first_q;
		count_n      = count_q;
		entry        = 1'b0;
		leave        = 1'b0;
		err          = 1'b0;
		if (zone_next != zone_now_q) begin
			if (zone_now_q == ZONE_NONE)
				zone_first_n = zone_next;
			if (zone_next == ZONE_NONE) begin
				priority if (zone_now_q == ZONE_B && zone_first_q == ZONE_A) begin
					entry = 1'b1;
					if (count_q != COUNT_MAX)
						count_n = count_q + COUNT_BITS'(1);
				end else if (zone_now_q == ZONE_A && zone_first_q == ZONE_B) begin
					leave = 1'b1;
					if (count_q != '0)
						count_n = count_q - COUNT_BITS'(1);
				end else if (zone_now_q == ZONE_BOTH || zone_first_q == ZONE_BOTH) begin
					err = 1'b1;
				end else begin
					err = 1'b0;
				end
				zone_first_n = ZONE_NONE;
			end
			zone_now_n = zone_next;
		end

		alarm = (32'(count_n) > 32'(alarm_above_q)) && (count_q < count_n);

		for (int i = 0; i < BAR_LEDS; i++)
			bar[i] = 32'(count_n) > i;

		result.occupancy      = count_n;
		result.entry_seen     = entry;
		result.exit_seen      = leave;
		result.pass_error     = err;
		result.capacity_alarm = alarm;
		result.level_bar      = bar;
		result.zone_code      = zone_now_n;
		result.clean_a        = beam_a_n.level;
		result.clean_b        = beam_b_n.level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= DEBOUNCE_RESET;
			alarm_above_q    <= ALARM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DEBOUNCE_LIMIT)
				debounce_limit_q <= cfg_data;
			else if (cfg_index == REG_ALARM_ABOVE)
				alarm_above_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_a_q     <= '0;
			beam_b_q     <= '0;
			zone_now_q   <= ZONE_NONE;
			zone_first_q <= ZONE_NONE;
			count_q      <= '0;
		end else if (in_fire) begin
			beam_a_q     <= beam_a_n;
			beam_b_q     <= beam_b_n;
			zone_now_q   <= zone_now_n;
			zone_first_q <= zone_first_n;
			count_q      <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire)
				skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire)
				out_q <= skid_q;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire)
				out_q <= result;
			else
				skid_q <= result;
		end
	end

endmodule
`default_nettype wire
